// ----- rtl/gnse_pkg.sv -----
// shared widths, command codes and controller/datapath types of the gate netlist step engine
`default_nettype none

package gnse_pkg;

    // field widths
    localparam int ID_W    = 12;
    localparam int KIND_W  = 5;
    localparam int CMD_W   = 2;
    localparam int CFG_W   = 11;
    localparam int GCNT_W  = 12;
    localparam int PIN_N   = 7;

    // command codes
    localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SET  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ = 2'd2;
    localparam logic [CMD_W-1:0] CMD_STEP = 2'd3;

    // pin pair read together during gate evaluation
    localparam logic [1:0] PAIR_LO  = 2'd0;
    localparam logic [1:0] PAIR_MID = 2'd1;
    localparam logic [1:0] PAIR_HI  = 2'd2;

    typedef logic [PIN_N-1:0][ID_W-1:0] pin_vec_t;

    // one gate table entry
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        pin_vec_t          pin;
    } gate_t;

    // controller to datapath
    typedef struct packed {
        logic       latch_in;
        logic       load_gate;
        logic       set_wire;
        logic       rd_wire;
        logic       clr_wr;
        logic       fetch;
        logic       pin_rd;
        logic [1:0] pin_pair;
        logic       cap_lo;
        logic       cap_hi;
        logic       eval;
        logic       out_wr;
        logic [1:0] out_sel;
        logic       gate_next;
        logic       res_load;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic gate_any;
        logic gate_last;
        logic wr_more;
    } dp_stat_t;

endpackage

`default_nettype wire

// ----- rtl/gnse_cmd_if.sv -----
// command channel: valid/ready handshake and the command payload
`default_nettype none

interface gnse_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [gnse_pkg::CMD_W-1:0]    cmd;
    logic [gnse_pkg::ID_W-1:0]     index;
    logic [gnse_pkg::KIND_W-1:0]   gate_kind;
    logic [gnse_pkg::ID_W-1:0]     pin_zero;
    logic [gnse_pkg::ID_W-1:0]     pin_one;
    logic [gnse_pkg::ID_W-1:0]     pin_two;
    logic [gnse_pkg::ID_W-1:0]     pin_three;
    logic [gnse_pkg::ID_W-1:0]     pin_four;
    logic [gnse_pkg::ID_W-1:0]     pin_five;
    logic [gnse_pkg::ID_W-1:0]     pin_six;
    logic                          bit_value;

    modport source (
        output valid, cmd, index, gate_kind, pin_zero, pin_one, pin_two, pin_three,
               pin_four, pin_five, pin_six, bit_value,
        input  ready
    );

    modport sink (
        input  valid, cmd, index, gate_kind, pin_zero, pin_one, pin_two, pin_three,
               pin_four, pin_five, pin_six, bit_value,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/gnse_resp_if.sv -----
// response channel: valid/ready handshake and the wire level
`default_nettype none

interface gnse_resp_if;
    logic valid;
    logic ready;
    logic wire_level;

    modport source (
        output valid, wire_level,
        input  ready
    );

    modport sink (
        input  valid, wire_level,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/gate_netlist_step_engine_unit.sv -----
// top level of the gate netlist step engine: controller, datapath and channel wiring
//
//  channel   dir   payload                                           transfer when
//  cmd_ch    in    cmd, index, gate_kind, pin_zero..pin_six, bit     valid && ready
//  resp_ch   out   wire_level                                        valid && ready
//  cfg       in    cfg_wr_data (gates per step)                      cfg_wr_en
//
// load, set and read: after the transfer the command passes its own state, then FINISH loads the
// response register. a step takes each gate through FETCH, RD0, RD1, RD2, EVAL and WRITE,
// with WRITE repeated for each further driven pin of a DMUX or DMUX4, then goes to FINISH;
// one gate table read, three paired bank reads and one bank write port on the next bank
// set these per-gate steps.
// after reset both banks are cleared over the whole bank depth with cmd_ch
// not ready. a finished response waits in its register while the next command runs;
// a command only stalls at its end if the previous response is still untaken.
`default_nettype none

module gate_netlist_step_engine_unit #(
    parameter int MAX_GATES = 1024,
    parameter int MAX_WIRES = 4096
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_wr_en,
    input  wire logic [gnse_pkg::CFG_W-1:0] cfg_wr_data,
    gnse_cmd_if.sink                        cmd_ch,
    gnse_resp_if.source                     resp_ch
);

    gnse_pkg::dp_cmd_t  dp_cmd;
    gnse_pkg::dp_stat_t dp_stat;
    gnse_pkg::pin_vec_t item_pins;

    // pins packed with pin zero at the bottom
    assign item_pins = {cmd_ch.pin_six, cmd_ch.pin_five, cmd_ch.pin_four, cmd_ch.pin_three,
                        cmd_ch.pin_two, cmd_ch.pin_one, cmd_ch.pin_zero};

    gnse_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (cmd_ch.valid),
        .item_cmd   (cmd_ch.cmd),
        .item_ready (cmd_ch.ready),
        .res_valid  (resp_ch.valid),
        .res_ready  (resp_ch.ready),
        .stat       (dp_stat),
        .cmd        (dp_cmd)
    );

    gnse_dp #(
        .MAX_GATES (MAX_GATES),
        .MAX_WIRES (MAX_WIRES)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item_cmd    (cmd_ch.cmd),
        .item_index  (cmd_ch.index),
        .item_kind   (cmd_ch.gate_kind),
        .item_pins   (item_pins),
        .item_bit    (cmd_ch.bit_value),
        .cmd         (dp_cmd),
        .stat        (dp_stat),
        .wire_level  (resp_ch.wire_level)
    );

`ifndef ASSERT_OFF
    // no command taken while the banks are being cleared
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_ch.ready |-> !dp_cmd.clr_wr)
        else $error("command channel ready during bank clear");

    // one command at a time: ready drops after a transfer
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_ch.valid && cmd_ch.ready) |=> !cmd_ch.ready)
        else $error("command channel ready right after a transfer");

    // a response is never overwritten before it is taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.res_load |-> (!resp_ch.valid || resp_ch.ready))
        else $error("response register loaded while holding an untaken response");
`endif

endmodule

`default_nettype wire

// ----- rtl/gnse_bank.sv -----
// one-bit wire bank: one write port, two registered read ports, range checked ids
`default_nettype none

module gnse_bank #(
    parameter int MAX_WIRES = 4096
) (
    input  wire logic                      clk,
    input  wire logic                      we,
    input  wire logic [gnse_pkg::ID_W-1:0] waddr,
    input  wire logic                      wdata,
    input  wire logic                      re,
    input  wire logic [gnse_pkg::ID_W-1:0] raddr0,
    input  wire logic [gnse_pkg::ID_W-1:0] raddr1,
    output logic                           rd_data0,
    output logic                           rd_data1
);

    localparam int ID_SPAN = 1 << gnse_pkg::ID_W;
    localparam int DEPTH   = (MAX_WIRES > ID_SPAN) ? ID_SPAN : MAX_WIRES;
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic bank_mem [DEPTH];
    logic rd0_reg;
    logic rd1_reg;

    // write, ids beyond the bank are dropped
    always_ff @(posedge clk)
    begin
        if (we && (32'(waddr) < MAX_WIRES))
        begin
            bank_mem[waddr[AW-1:0]] <= wdata;
        end
    end

    // registered reads, ids beyond the bank read as low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rd0_reg <= (32'(raddr0) < MAX_WIRES) ? bank_mem[raddr0[AW-1:0]] : 1'b0;
            rd1_reg <= (32'(raddr1) < MAX_WIRES) ? bank_mem[raddr1[AW-1:0]] : 1'b0;
        end
    end

    assign rd_data0 = rd0_reg;
    assign rd_data1 = rd1_reg;

endmodule

`default_nettype wire

// ----- rtl/gnse_dp.sv -----
// datapath: gate table, two wire banks, pin value registers, gate evaluation, result data
`default_nettype none

module gnse_dp #(
    parameter int MAX_GATES = 1024,
    parameter int MAX_WIRES = 4096
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_wr_en,
    input  wire logic [gnse_pkg::CFG_W-1:0]  cfg_wr_data,
    input  wire logic [gnse_pkg::CMD_W-1:0]  item_cmd,
    input  wire logic [gnse_pkg::ID_W-1:0]   item_index,
    input  wire logic [gnse_pkg::KIND_W-1:0] item_kind,
    input  wire gnse_pkg::pin_vec_t          item_pins,
    input  wire logic                        item_bit,
    input  wire gnse_pkg::dp_cmd_t           cmd,
    output gnse_pkg::dp_stat_t               stat,
    output logic                             wire_level
);

    localparam int IW         = gnse_pkg::ID_W;
    localparam int CW         = gnse_pkg::GCNT_W;
    localparam int ID_SPAN    = 1 << IW;
    localparam int GATE_DEPTH = (MAX_GATES > ID_SPAN) ? ID_SPAN : MAX_GATES;
    localparam int GA         = (GATE_DEPTH > 1) ? $clog2(GATE_DEPTH) : 1;
    localparam int WIRE_DEPTH = (MAX_WIRES > ID_SPAN) ? ID_SPAN : MAX_WIRES;
    localparam int WA         = (WIRE_DEPTH > 1) ? $clog2(WIRE_DEPTH) : 1;

    // gate kind codes
    localparam logic [4:0] K_BUF   = 5'd0;
    localparam logic [4:0] K_NOT   = 5'd1;
    localparam logic [4:0] K_AND   = 5'd2;
    localparam logic [4:0] K_NAND  = 5'd3;
    localparam logic [4:0] K_OR    = 5'd4;
    localparam logic [4:0] K_NOR   = 5'd5;
    localparam logic [4:0] K_XOR   = 5'd6;
    localparam logic [4:0] K_AND3  = 5'd7;
    localparam logic [4:0] K_NAND3 = 5'd8;
    localparam logic [4:0] K_OR3   = 5'd9;
    localparam logic [4:0] K_NOR3  = 5'd10;
    localparam logic [4:0] K_AND4  = 5'd11;
    localparam logic [4:0] K_NAND4 = 5'd12;
    localparam logic [4:0] K_OR4   = 5'd13;
    localparam logic [4:0] K_NOR4  = 5'd14;
    localparam logic [4:0] K_MUX   = 5'd15;
    localparam logic [4:0] K_MUX4  = 5'd16;
    localparam logic [4:0] K_DMUX  = 5'd17;
    localparam logic [4:0] K_DMUX4 = 5'd18;

    // returns {write mask, output levels} for pins 0..3
    function automatic logic [7:0] eval_gate(
        input logic [4:0] kind,
        input logic a,
        input logic b,
        input logic c,
        input logic d,
        input logic s0,
        input logic s1
    );
        logic       r;
        logic [3:0] m;
        logic [3:0] o;
        logic [3:0] dec;
        r   = 1'b0;
        m   = 4'b0001;
        o   = 4'b0000;
        dec = 4'b0001 << {s1, s0};
        case (kind)
            K_BUF:   r = a;
            K_NOT:   r = ~a;
            K_AND:   r = a & b;
            K_NAND:  r = ~(a & b);
            K_OR:    r = a | b;
            K_NOR:   r = ~(a | b);
            K_XOR:   r = a ^ b;
            K_AND3:  r = a & b & c;
            K_NAND3: r = ~(a & b & c);
            K_OR3:   r = a | b | c;
            K_NOR3:  r = ~(a | b | c);
            K_AND4:  r = a & b & c & d;
            K_NAND4: r = ~(a & b & c & d);
            K_OR4:   r = a | b | c | d;
            K_NOR4:  r = ~(a | b | c | d);
            K_MUX:   r = c ? b : a;
            K_MUX4:  r = s1 ? (s0 ? d : c) : (s0 ? b : a);
            K_DMUX:  m = 4'b0011;
            K_DMUX4: m = 4'b1111;
            default: m = 4'b0000;
        endcase
        if (kind == K_DMUX)
        begin
            o = {2'b00, b & c, b & ~c};
        end
        else if (kind == K_DMUX4)
        begin
            o = dec & {4{d}};
        end
        else
        begin
            o = {3'b000, r};
        end
        return {m, o};
    endfunction

    logic [gnse_pkg::CFG_W-1:0]  step_len_reg;
    logic                        bank_sel_reg;
    logic [WA-1:0]               clr_cnt_reg;
    logic [CW-1:0]               gate_cnt_reg;
    logic [gnse_pkg::CMD_W-1:0]  cmd_reg;
    logic [IW-1:0]               idx_reg;
    logic [gnse_pkg::KIND_W-1:0] kind_reg;
    gnse_pkg::pin_vec_t          pins_reg;
    logic                        bit_reg;
    gnse_pkg::gate_t             gate_mem [GATE_DEPTH];
    gnse_pkg::gate_t             gate_reg;
    logic [3:0]                  val_reg;
    logic [3:0]                  lvl_reg;
    logic [3:0]                  mask_reg;
    logic                        level_reg;

    logic [CW-1:0] n_sat;
    logic [IW-1:0] raddr0;
    logic [IW-1:0] raddr1;
    logic          rd_en;
    logic [IW-1:0] waddr;
    logic          wdata;
    logic          we_a;
    logic          we_b;
    logic          wr_hit;
    logic          a_rd0;
    logic          a_rd1;
    logic          b_rd0;
    logic          b_rd1;
    logic          cur0;
    logic          cur1;
    logic [7:0]    eval_res;

    // gate count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_len_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            step_len_reg <= cfg_wr_data;
        end
    end

    // gates walked per step, capped at the table depth
    assign n_sat = (32'(step_len_reg) > MAX_GATES) ? CW'(MAX_GATES) : CW'(step_len_reg);

    // control state: current bank select and clear pass address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_sel_reg <= 1'b0;
            clr_cnt_reg  <= '0;
        end
        else
        begin
            if (cmd.clr_wr)
            begin
                clr_cnt_reg <= clr_cnt_reg + WA'(1);
            end
            if (cmd.res_load && (cmd_reg == gnse_pkg::CMD_STEP))
            begin
                bank_sel_reg <= ~bank_sel_reg;
            end
        end
    end

    // command capture and gate walk counter
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            cmd_reg      <= item_cmd;
            idx_reg      <= item_index;
            kind_reg     <= item_kind;
            pins_reg     <= item_pins;
            bit_reg      <= item_bit;
            gate_cnt_reg <= '0;
        end
        else if (cmd.gate_next)
        begin
            gate_cnt_reg <= gate_cnt_reg + CW'(1);
        end
    end

    // gate table, loads beyond the table are dropped
    always_ff @(posedge clk)
    begin
        if (cmd.load_gate && (32'(idx_reg) < MAX_GATES))
        begin
            gate_mem[idx_reg[GA-1:0]] <= {kind_reg, pins_reg};
        end
        if (cmd.fetch)
        begin
            gate_reg <= gate_mem[gate_cnt_reg[GA-1:0]];
        end
    end

    // bank read addresses
    always_comb
    begin
        raddr0 = idx_reg;
        raddr1 = idx_reg;
        if (!cmd.rd_wire)
        begin
            case (cmd.pin_pair)
                gnse_pkg::PAIR_LO:
                begin
                    raddr0 = gate_reg.pin[1];
                    raddr1 = gate_reg.pin[2];
                end
                gnse_pkg::PAIR_MID:
                begin
                    raddr0 = gate_reg.pin[3];
                    raddr1 = gate_reg.pin[4];
                end
                gnse_pkg::PAIR_HI:
                begin
                    raddr0 = gate_reg.pin[5];
                    raddr1 = gate_reg.pin[6];
                end
                default:
                begin
                    raddr0 = idx_reg;
                    raddr1 = idx_reg;
                end
            endcase
        end
    end

    assign rd_en = cmd.rd_wire | cmd.pin_rd;

    // bank writes: clear pass and set wire hit both banks, gate outputs the next bank
    always_comb
    begin
        waddr  = IW'(clr_cnt_reg);
        wdata  = 1'b0;
        we_a   = 1'b0;
        we_b   = 1'b0;
        wr_hit = mask_reg[cmd.out_sel];
        if (cmd.clr_wr)
        begin
            we_a = 1'b1;
            we_b = 1'b1;
        end
        else if (cmd.set_wire)
        begin
            waddr = idx_reg;
            wdata = bit_reg;
            we_a  = 1'b1;
            we_b  = 1'b1;
        end
        else if (cmd.out_wr)
        begin
            waddr = gate_reg.pin[3'(cmd.out_sel)];
            wdata = lvl_reg[cmd.out_sel];
            we_a  = wr_hit & bank_sel_reg;
            we_b  = wr_hit & ~bank_sel_reg;
        end
    end

    gnse_bank #(
        .MAX_WIRES (MAX_WIRES)
    ) u_bank_a (
        .clk      (clk),
        .we       (we_a),
        .waddr    (waddr),
        .wdata    (wdata),
        .re       (rd_en),
        .raddr0   (raddr0),
        .raddr1   (raddr1),
        .rd_data0 (a_rd0),
        .rd_data1 (a_rd1)
    );

    gnse_bank #(
        .MAX_WIRES (MAX_WIRES)
    ) u_bank_b (
        .clk      (clk),
        .we       (we_b),
        .waddr    (waddr),
        .wdata    (wdata),
        .re       (rd_en),
        .raddr0   (raddr0),
        .raddr1   (raddr1),
        .rd_data0 (b_rd0),
        .rd_data1 (b_rd1)
    );

    // read data from the current bank
    assign cur0 = bank_sel_reg ? b_rd0 : a_rd0;
    assign cur1 = bank_sel_reg ? b_rd1 : a_rd1;

    // pins 5 and 6 come straight from the bank in the evaluate cycle
    assign eval_res = eval_gate(gate_reg.kind, val_reg[0], val_reg[1], val_reg[2],
                                val_reg[3], cur0, cur1);

    // pin values, gate outputs and result level
    always_ff @(posedge clk)
    begin
        if (cmd.cap_lo)
        begin
            val_reg[1:0] <= {cur1, cur0};
        end
        if (cmd.cap_hi)
        begin
            val_reg[3:2] <= {cur1, cur0};
        end
        if (cmd.eval)
        begin
            mask_reg <= eval_res[7:4];
            lvl_reg  <= eval_res[3:0];
        end
        if (cmd.res_load)
        begin
            level_reg <= (cmd_reg == gnse_pkg::CMD_READ) ? cur0 : 1'b0;
        end
    end

    // status to the controller
    assign stat.clr_last  = (clr_cnt_reg == WA'(WIRE_DEPTH - 1));
    assign stat.gate_any  = (n_sat != '0);
    assign stat.gate_last = ((gate_cnt_reg + CW'(1)) == n_sat);
    assign stat.wr_more   = (cmd.out_sel != 2'd3) && mask_reg[cmd.out_sel + 2'd1];

    assign wire_level = level_reg;

endmodule

`default_nettype wire

// ----- rtl/gnse_ctrl.sv -----
// controller: command sequencing, gate walk sequencing and response valid
`default_nettype none

module gnse_ctrl (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       item_valid,
    input  wire logic [gnse_pkg::CMD_W-1:0] item_cmd,
    output logic                            item_ready,
    output logic                            res_valid,
    input  wire logic                       res_ready,
    input  wire gnse_pkg::dp_stat_t         stat,
    output gnse_pkg::dp_cmd_t               cmd
);

    localparam logic [3:0] ST_CLEAR  = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_LOAD   = 4'd2;
    localparam logic [3:0] ST_SET    = 4'd3;
    localparam logic [3:0] ST_READ   = 4'd4;
    localparam logic [3:0] ST_FETCH  = 4'd5;
    localparam logic [3:0] ST_RD0    = 4'd6;
    localparam logic [3:0] ST_RD1    = 4'd7;
    localparam logic [3:0] ST_RD2    = 4'd8;
    localparam logic [3:0] ST_EVAL   = 4'd9;
    localparam logic [3:0] ST_WRITE  = 4'd10;
    localparam logic [3:0] ST_FINISH = 4'd11;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic [1:0] wr_sel_reg;
    logic [1:0] wr_sel_next;
    logic       res_valid_reg;
    logic       res_valid_next;

    // next state and datapath commands
    always_comb
    begin
        state_next     = state_reg;
        wr_sel_next    = wr_sel_reg;
        res_valid_next = res_valid_reg & ~res_ready;
        cmd            = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.latch_in = 1'b1;
                    case (item_cmd)
                        gnse_pkg::CMD_LOAD: state_next = ST_LOAD;
                        gnse_pkg::CMD_SET:  state_next = ST_SET;
                        gnse_pkg::CMD_READ: state_next = ST_READ;
                        gnse_pkg::CMD_STEP: state_next = stat.gate_any ? ST_FETCH : ST_FINISH;
                        default:            state_next = ST_FINISH;
                    endcase
                end
            end
            ST_LOAD:
            begin
                cmd.load_gate = 1'b1;
                state_next    = ST_FINISH;
            end
            ST_SET:
            begin
                cmd.set_wire = 1'b1;
                state_next   = ST_FINISH;
            end
            ST_READ:
            begin
                cmd.rd_wire = 1'b1;
                state_next  = ST_FINISH;
            end
            ST_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = ST_RD0;
            end
            ST_RD0:
            begin
                cmd.pin_rd   = 1'b1;
                cmd.pin_pair = gnse_pkg::PAIR_LO;
                state_next   = ST_RD1;
            end
            ST_RD1:
            begin
                cmd.cap_lo   = 1'b1;
                cmd.pin_rd   = 1'b1;
                cmd.pin_pair = gnse_pkg::PAIR_MID;
                state_next   = ST_RD2;
            end
            ST_RD2:
            begin
                cmd.cap_hi   = 1'b1;
                cmd.pin_rd   = 1'b1;
                cmd.pin_pair = gnse_pkg::PAIR_HI;
                state_next   = ST_EVAL;
            end
            ST_EVAL:
            begin
                cmd.eval    = 1'b1;
                wr_sel_next = 2'd0;
                state_next  = ST_WRITE;
            end
            ST_WRITE:
            begin
                cmd.out_wr  = 1'b1;
                cmd.out_sel = wr_sel_reg;
                if (stat.wr_more)
                begin
                    wr_sel_next = wr_sel_reg + 2'd1;
                end
                else
                begin
                    cmd.gate_next = 1'b1;
                    state_next    = stat.gate_last ? ST_FINISH : ST_FETCH;
                end
            end
            ST_FINISH:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    cmd.res_load   = 1'b1;
                    res_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            wr_sel_reg    <= 2'd0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wr_sel_reg    <= wr_sel_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign item_ready = (state_reg == ST_IDLE);
    assign res_valid  = res_valid_reg;

endmodule

`default_nettype wire

// ----- tb/sv/gnse_tb_pkg.sv -----
// testbench package: gate kinds, command record and the netlist mirror that predicts responses
package gnse_tb_pkg;
    import gnse_pkg::*;

    localparam int GATE_DEPTH = 1024;
    localparam int WIRE_DEPTH = 4096;

    // gate kinds understood by the engine
    typedef enum logic [KIND_W-1:0] {
        GK_BUF = 5'd0, GK_NOT, GK_AND, GK_NAND, GK_OR, GK_NOR, GK_XOR,
        GK_AND3, GK_NAND3, GK_OR3, GK_NOR3, GK_AND4, GK_NAND4, GK_OR4, GK_NOR4,
        GK_MUX, GK_MUX4, GK_DMUX, GK_DMUX4
    } gate_kind_e;

    // kinds above the last real one drive nothing
    localparam logic [KIND_W-1:0] KIND_SPARE_LO = 5'd19;
    localparam logic [KIND_W-1:0] KIND_SPARE_HI = 5'd31;

    // one command as presented on the command channel
    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [ID_W-1:0]   index;
        logic [KIND_W-1:0] kind;
        pin_vec_t          pin;
        logic              bit_value;
    } command_t;

    // mirror of the gate table and wire banks, with the queue of levels still due
    class netlist_mirror;
        logic [KIND_W-1:0] kinds [GATE_DEPTH];
        pin_vec_t          pins [GATE_DEPTH];
        bit                loaded [GATE_DEPTH];
        bit                bank [2][WIRE_DEPTH];
        bit                cur_bank;
        int                step_len;
        bit                levels_due [$];
        int                faults;

        function new();
            cur_bank = 1'b0;
            step_len = 0;
            faults   = 0;
            foreach (loaded[g])
                loaded[g] = 1'b0;
            foreach (bank[b, w])
                bank[b][w] = 1'b0;
        endfunction

        function void set_step_len(int value);
            step_len = value;
        endfunction

        function int pending();
            return levels_due.size();
        endfunction

        // counts above the table depth saturate
        function int gates_walked();
            return (step_len > GATE_DEPTH) ? GATE_DEPTH : step_len;
        endfunction

        // a step may only walk entries that have been loaded
        function bit step_allowed();
            for (int g = 0; g < gates_walked(); g++)
                if (!loaded[g])
                    return 1'b0;
            return 1'b1;
        endfunction

        // write one gate pin's wire in the next bank
        function void put(int g, int k, bit value);
            bank[~cur_bank][pins[g][k]] = value;
        endfunction

        // walk the table in order, reading the current bank, later gates win
        function void run_step();
            bit v [PIN_N];
            int sel;
            for (int g = 0; g < gates_walked(); g++)
            begin
                for (int i = 0; i < PIN_N; i++)
                    v[i] = bank[cur_bank][pins[g][i]];
                sel = 2 * v[6] + v[5];
                case (kinds[g])
                    GK_BUF:   put(g, 0, v[1]);
                    GK_NOT:   put(g, 0, !v[1]);
                    GK_AND:   put(g, 0, v[1] & v[2]);
                    GK_NAND:  put(g, 0, !(v[1] & v[2]));
                    GK_OR:    put(g, 0, v[1] | v[2]);
                    GK_NOR:   put(g, 0, !(v[1] | v[2]));
                    GK_XOR:   put(g, 0, v[1] ^ v[2]);
                    GK_AND3:  put(g, 0, v[1] & v[2] & v[3]);
                    GK_NAND3: put(g, 0, !(v[1] & v[2] & v[3]));
                    GK_OR3:   put(g, 0, v[1] | v[2] | v[3]);
                    GK_NOR3:  put(g, 0, !(v[1] | v[2] | v[3]));
                    GK_AND4:  put(g, 0, v[1] & v[2] & v[3] & v[4]);
                    GK_NAND4: put(g, 0, !(v[1] & v[2] & v[3] & v[4]));
                    GK_OR4:   put(g, 0, v[1] | v[2] | v[3] | v[4]);
                    GK_NOR4:  put(g, 0, !(v[1] | v[2] | v[3] | v[4]));
                    GK_MUX:   put(g, 0, v[3] ? v[2] : v[1]);
                    GK_MUX4:  put(g, 0, v[1 + sel]);
                    GK_DMUX:
                    begin
                        put(g, 0, v[2] & !v[3]);
                        put(g, 1, v[2] & v[3]);
                    end
                    GK_DMUX4:
                    begin
                        for (int k = 0; k < 4; k++)
                            put(g, k, v[4] && (sel == k));
                    end
                    default: ;
                endcase
            end
        endfunction

        // note one command transfer and queue the level it must answer with
        function void accept_command(command_t c);
            bit level;
            level = 1'b0;
            case (c.cmd)
                CMD_LOAD:
                begin
                    if (c.index < GATE_DEPTH)
                    begin
                        kinds[c.index]  = c.kind;
                        pins[c.index]   = c.pin;
                        loaded[c.index] = 1'b1;
                    end
                end
                CMD_SET:
                begin
                    bank[0][c.index] = c.bit_value;
                    bank[1][c.index] = c.bit_value;
                end
                CMD_READ:
                    level = bank[cur_bank][c.index];
                CMD_STEP:
                begin
                    run_step();
                    cur_bank = ~cur_bank;
                end
                default: ;
            endcase
            levels_due = {levels_due, level};
        endfunction

        // compare one response transfer with the oldest level due
        function void check_level(logic actual);
            bit expected;
            if (levels_due.size() == 0)
            begin
                $error("wire_level: response with no command waiting, got %0b", actual);
                faults++;
                return;
            end
            expected = levels_due.pop_front();
            if (actual !== expected)
            begin
                $error("wire_level mismatch: expected %0b, got %0b", expected, actual);
                faults++;
            end
        endfunction
    endclass

endpackage

// ----- tb/sv/tb.sv -----
// top of the testbench: clock, reset, command and response drivers, stimulus and end check
module tb;
    import gnse_pkg::*;
    import gnse_tb_pkg::*;

    localparam int QUIET_LIMIT = 50000;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [CFG_W-1:0]  cfg_wr_data;
    bit                calm;
    int                quiet_cycles = 0;
    netlist_mirror     model = new();

    gnse_cmd_if  cmd_ch ();
    gnse_resp_if resp_ch ();

    gate_netlist_step_engine_unit u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd_ch      (cmd_ch),
        .resp_ch     (resp_ch)
    );

    always #2 clk = ~clk;

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // wire ids mostly from a small pool so that gates interact
    function automatic logic [ID_W-1:0] pick_wire();
        if ($urandom_range(0, 7) == 0)
            return ID_W'($urandom);
        return ID_W'($urandom_range(0, 15));
    endfunction

    function automatic command_t wire_cmd(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] idx,
                                          logic bit_value);
        command_t c;
        c           = '0;
        c.cmd       = cmd;
        c.index     = idx;
        c.bit_value = bit_value;
        return c;
    endfunction

    function automatic command_t gate_cmd(logic [ID_W-1:0] idx, logic [KIND_W-1:0] kind,
                                          int p0, int p1, int p2, int p3, int p4,
                                          int p5, int p6);
        command_t c;
        c       = '0;
        c.cmd   = CMD_LOAD;
        c.index = idx;
        c.kind  = kind;
        c.pin   = {ID_W'(p6), ID_W'(p5), ID_W'(p4), ID_W'(p3), ID_W'(p2), ID_W'(p1),
                   ID_W'(p0)};
        return c;
    endfunction

    // load of one gate with random kind and wiring
    function automatic command_t random_gate(logic [ID_W-1:0] idx);
        command_t c;
        c.cmd   = CMD_LOAD;
        c.index = idx;
        if ($urandom_range(0, 9) == 0)
            c.kind = KIND_W'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
        else
            c.kind = KIND_W'($urandom_range(GK_BUF, GK_DMUX4));
        for (int i = 0; i < PIN_N; i++)
            c.pin[i] = pick_wire();
        c.bit_value = 1'($urandom_range(0, 1));
        return c;
    endfunction

    // random command; unused fields carry noise
    function automatic command_t random_command(int n_gates);
        command_t c;
        int       pick;
        int       top;
        c.kind = KIND_W'($urandom);
        for (int i = 0; i < PIN_N; i++)
            c.pin[i] = ID_W'($urandom);
        c.bit_value = 1'($urandom_range(0, 1));
        c.index     = pick_wire();
        pick        = $urandom_range(0, 99);
        if (pick < 20)
        begin
            top  = (n_gates + 3 > GATE_DEPTH - 1) ? GATE_DEPTH - 1 : n_gates + 3;
            pick = $urandom_range(0, 9);
            if (pick < 7)
                c = random_gate(ID_W'($urandom_range(0, top)));
            else if (pick < 9)
                c = random_gate(ID_W'($urandom_range(0, GATE_DEPTH - 1)));
            else
                c = random_gate(ID_W'($urandom_range(GATE_DEPTH, WIRE_DEPTH - 1)));
        end
        else if (pick < 45)
        begin
            c.cmd = CMD_SET;
        end
        else if (pick < 80 || !model.step_allowed())
        begin
            c.cmd = CMD_READ;
        end
        else
        begin
            c.cmd = CMD_STEP;
        end
        return c;
    endfunction

    // present one command and wait for its transfer
    task automatic send(input command_t c);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid     <= 1'b1;
        cmd_ch.cmd       <= c.cmd;
        cmd_ch.index     <= c.index;
        cmd_ch.gate_kind <= c.kind;
        cmd_ch.pin_zero  <= c.pin[0];
        cmd_ch.pin_one   <= c.pin[1];
        cmd_ch.pin_two   <= c.pin[2];
        cmd_ch.pin_three <= c.pin[3];
        cmd_ch.pin_four  <= c.pin[4];
        cmd_ch.pin_five  <= c.pin[5];
        cmd_ch.pin_six   <= c.pin[6];
        cmd_ch.bit_value <= c.bit_value;
        do
            @(posedge clk);
        while (cmd_ch.ready !== 1'b1);
        model.accept_command(c);
    endtask

    // register write only once the engine has drained
    task automatic write_step_len(input logic [CFG_W-1:0] value);
        cmd_ch.valid <= 1'b0;
        while (model.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        model.set_step_len(int'(value));
    endtask

    // fresh netlist of n_gates random gates, then a random mix of commands
    task automatic run_round(input int n_gates, input int n_items);
        calm = ($urandom_range(0, 3) == 0);
        write_step_len(CFG_W'(n_gates));
        for (int g = 0; g < n_gates; g++)
            send(random_gate(ID_W'(g)));
        for (int i = 0; i < n_items; i++)
            send(random_command(n_gates));
    endtask

    // response side: check each transfer, then stall at random
    initial
    begin
        int hold;
        resp_ch.ready = 1'b0;
        hold          = 0;
        forever
        begin
            @(posedge clk);
            if (resp_ch.valid === 1'b1 && resp_ch.ready === 1'b1)
                model.check_level(resp_ch.wire_level);
            if (hold > 0)
            begin
                hold--;
                resp_ch.ready <= 1'b0;
            end
            else
            begin
                resp_ch.ready <= 1'b1;
                hold = pick_gap();
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((cmd_ch.valid && cmd_ch.ready) || (resp_ch.valid && resp_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        rst_n            = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_wr_data      = '0;
        cmd_ch.valid     = 1'b0;
        cmd_ch.cmd       = CMD_LOAD;
        cmd_ch.index     = '0;
        cmd_ch.gate_kind = '0;
        cmd_ch.pin_zero  = '0;
        cmd_ch.pin_one   = '0;
        cmd_ch.pin_two   = '0;
        cmd_ch.pin_three = '0;
        cmd_ch.pin_four  = '0;
        cmd_ch.pin_five  = '0;
        cmd_ch.pin_six   = '0;
        cmd_ch.bit_value = 1'b0;
        calm             = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // reset levels, extreme wire ids, step over an empty table
        send(wire_cmd(CMD_READ, 0, 1'b0));
        send(wire_cmd(CMD_READ, 4095, 1'b0));
        send(wire_cmd(CMD_SET, 4095, 1'b1));
        send(wire_cmd(CMD_READ, 4095, 1'b0));
        send(wire_cmd(CMD_SET, 0, 1'b1));
        send(wire_cmd(CMD_STEP, 0, 1'b0));
        send(wire_cmd(CMD_READ, 0, 1'b0));

        // loads past the table are dropped
        send(gate_cmd(4095, KIND_SPARE_HI, 4095, 4095, 4095, 4095, 4095, 4095, 4095));
        send(gate_cmd(GATE_DEPTH, GK_NOT, 1, 1, 1, 1, 1, 1, 1));

        // small netlist: decoders, wide mux, and a later gate overriding wire 10
        send(gate_cmd(0, GK_DMUX4, 10, 11, 12, 13, 0, 5, 6));
        send(gate_cmd(1, GK_MUX4, 20, 0, 4095, 10, 11, 5, 6));
        send(gate_cmd(2, GK_DMUX, 21, 22, 0, 4095, 0, 0, 0));
        send(gate_cmd(3, GK_NOT, 10, 4095, 0, 0, 0, 0, 0));
        send(gate_cmd(GATE_DEPTH - 1, GK_BUF, 0, 0, 0, 0, 0, 0, 0));
        write_step_len(CFG_W'(4));
        send(wire_cmd(CMD_STEP, 0, 1'b0));
        send(wire_cmd(CMD_READ, 10, 1'b0));
        send(wire_cmd(CMD_READ, 20, 1'b0));
        send(wire_cmd(CMD_READ, 21, 1'b0));
        send(wire_cmd(CMD_READ, 22, 1'b0));
        send(wire_cmd(CMD_SET, 5, 1'b1));
        send(wire_cmd(CMD_STEP, 0, 1'b0));
        send(wire_cmd(CMD_READ, 11, 1'b0));
        send(wire_cmd(CMD_READ, 20, 1'b0));

        // random netlists, mostly small
        run_round(1, 30);
        for (int r = 0; r < 10; r++)
            run_round((r == 5) ? 64 : $urandom_range(0, 24), 35);

        // counts at and above the table depth, then zero
        calm = 1'b0;
        write_step_len(CFG_W'(GATE_DEPTH));
        for (int i = 0; i < 3; i++)
            send(random_command(8));
        write_step_len({CFG_W{1'b1}});
        for (int i = 0; i < 3; i++)
            send(random_command(8));
        write_step_len(CFG_W'($urandom_range(GATE_DEPTH + 1, 2046)));
        for (int i = 0; i < 3; i++)
            send(random_command(8));
        write_step_len('0);
        for (int i = 0; i < 3; i++)
            send(random_command(8));

        // drain
        cmd_ch.valid <= 1'b0;
        while (model.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (model.faults == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
